[rtl/lbr_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the 48-bit LCG bounded random source.
package lbr_pkg;

   localparam int STATE_W = 48;
   localparam int MUL_W   = 35;
   localparam int DRAW_W  = 31;
   localparam int VALUE_W = 32;
   localparam int SEED_W  = 64;
   localparam int BITS_W  = 6;
   localparam int MODE_W  = 2;
   localparam int CNT_W   = 6;

   localparam logic [STATE_W-1:0] LCG_MUL = 48'h0005_DEEC_E66D;
   localparam logic [STATE_W-1:0] LCG_ADD = 48'h0000_0000_000B;

   typedef enum logic [MODE_W-1:0] {
      MODE_RESEED  = 2'd0,
      MODE_RAW     = 2'd1,
      MODE_BOUNDED = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_POST,
      ST_SHIFT,
      ST_DIV,
      ST_CHECK,
      ST_RESULT
   } state_type;

endpackage

[rtl/lbr_req_if.sv]
`timescale 1ns / 1ps
// Request channel: mode, seed and draw parameters.
interface lbr_req_if;
   logic                                valid;
   logic                                ready;
   logic [lbr_pkg::MODE_W-1:0]          mode;
   logic signed [lbr_pkg::SEED_W-1:0]   seed_in;
   logic [lbr_pkg::BITS_W-1:0]          bits_wanted;
   logic signed [lbr_pkg::VALUE_W-1:0]  bound;

   modport source(output valid, mode, seed_in, bits_wanted, bound, input ready);
   modport sink(input valid, mode, seed_in, bits_wanted, bound, output ready);
endinterface

[rtl/lbr_rsp_if.sv]
`timescale 1ns / 1ps
// Response channel: drawn value and bad bound flag.
interface lbr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [lbr_pkg::VALUE_W-1:0]  value;
   logic                                bad_bound;

   modport source(output valid, value, bad_bound, input ready);
   modport sink(input valid, value, bad_bound, output ready);
endinterface

[rtl/lcg48_bounded_random_top.sv]
`timescale 1ns / 1ps
// Top level of the 48-bit LCG random source with raw and bounded draws.
// One request is worked on at a time. A reseed returns nothing. A raw draw steps the generator
// with a shift-add multiplier that handles one multiplier bit per cycle, takes the top bits in
// the post state and passes them through the result state to the output register. A bounded
// draw adds a restoring divider that takes one dividend bit per cycle plus a rejection check;
// a rejected attempt repeats the whole step. A power-of-two bound replaces the divider and
// check with a right shift of one bit per cycle. A bound of zero or less goes from the request
// straight to the result state and is presented from the output register with bad_bound set.
// The finished result sits in an output register, so a new request is taken while it waits;
// a second finished result waits for that register and holds off the input until it frees.
module lcg48_bounded_random_top (
   input  logic       clock,
   input  logic       reset,
   lbr_req_if.sink    req_ch,
   lbr_rsp_if.source  rsp_ch
);

   lbr_pkg::state_type                 state_ff, state_in;
   lbr_pkg::mode_type                  mode_ff, mode_in;
   logic [lbr_pkg::STATE_W-1:0]        lcg_ff, lcg_in;
   logic [lbr_pkg::STATE_W-1:0]        acc_ff, acc_in;
   logic [lbr_pkg::STATE_W-1:0]        mcand_ff, mcand_in;
   logic [lbr_pkg::CNT_W-1:0]          cnt_ff, cnt_in;
   logic [lbr_pkg::BITS_W-1:0]         bits_ff, bits_in;
   logic [lbr_pkg::VALUE_W-1:0]        bound_ff, bound_in;
   logic [lbr_pkg::DRAW_W-1:0]         dsh_ff, dsh_in;
   logic [lbr_pkg::DRAW_W-1:0]         rem_ff, rem_in;
   logic [lbr_pkg::VALUE_W-1:0]        pw_ff, pw_in;
   logic [lbr_pkg::VALUE_W-1:0]        res_value_ff, res_value_in;
   logic                               res_bad_ff, res_bad_in;
   logic [lbr_pkg::VALUE_W-1:0]        value_ff, value_in;
   logic                               bad_ff, bad_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   logic                               req_xfer;
   logic                               out_free;
   logic                               req_bad;
   logic                               mul_last;
   logic                               div_last;
   logic                               pow2;
   logic                               reject;
   logic [lbr_pkg::STATE_W-1:0]        mul_sum;
   logic [lbr_pkg::VALUE_W-1:0]        rem_trial;
   logic [lbr_pkg::VALUE_W-1:0]        check_sum;
   logic [lbr_pkg::BITS_W-1:0]         bits_sat;
   logic [lbr_pkg::BITS_W-1:0]         raw_shift;
   logic [lbr_pkg::VALUE_W-1:0]        raw_value;

   assign req_ch.ready = (state_ff == lbr_pkg::ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_bad      = (req_ch.bound == '0) || req_ch.bound[lbr_pkg::VALUE_W-1];

   assign mul_last = (cnt_ff == lbr_pkg::CNT_W'(lbr_pkg::MUL_W - 1));
   assign div_last = (cnt_ff == lbr_pkg::CNT_W'(lbr_pkg::DRAW_W - 1));
   assign mul_sum  = acc_ff + (lbr_pkg::LCG_MUL[cnt_ff] ? mcand_ff : '0);
   assign pow2     = ((bound_ff & (bound_ff - 1'b1)) == '0);

   assign rem_trial = {1'b0, rem_ff} << 1 | lbr_pkg::VALUE_W'(dsh_ff[lbr_pkg::DRAW_W-1]);
   assign check_sum = {1'b0, dsh_ff} - {1'b0, rem_ff} + (bound_ff - 1'b1);
   assign reject    = check_sum[lbr_pkg::VALUE_W-1];

   // top bits of the state, saturated to 32
   assign bits_sat  = (bits_ff > lbr_pkg::BITS_W'(lbr_pkg::VALUE_W)) ?
                      lbr_pkg::BITS_W'(lbr_pkg::VALUE_W) : bits_ff;
   assign raw_shift = lbr_pkg::BITS_W'(lbr_pkg::VALUE_W) - bits_sat;
   assign raw_value = (bits_ff == '0) ? '0 :
                      lcg_ff[lbr_pkg::STATE_W-1 -: lbr_pkg::VALUE_W] >> raw_shift;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lbr_pkg::ST_IDLE: begin
            if (req_xfer) begin
               case (lbr_pkg::mode_type'(req_ch.mode))
                  lbr_pkg::MODE_RAW:     state_in = lbr_pkg::ST_MUL;
                  lbr_pkg::MODE_BOUNDED: state_in = req_bad ? lbr_pkg::ST_RESULT
                                                            : lbr_pkg::ST_MUL;
                  default:               state_in = lbr_pkg::ST_IDLE;
               endcase
            end
         end
         lbr_pkg::ST_MUL: begin
            if (mul_last) state_in = lbr_pkg::ST_POST;
         end
         lbr_pkg::ST_POST: begin
            if (mode_ff == lbr_pkg::MODE_RAW) state_in = lbr_pkg::ST_RESULT;
            else if (pow2)                    state_in = lbr_pkg::ST_SHIFT;
            else                              state_in = lbr_pkg::ST_DIV;
         end
         lbr_pkg::ST_SHIFT: begin
            if (pw_ff[lbr_pkg::VALUE_W-1]) state_in = lbr_pkg::ST_RESULT;
         end
         lbr_pkg::ST_DIV: begin
            if (div_last) state_in = lbr_pkg::ST_CHECK;
         end
         lbr_pkg::ST_CHECK: begin
            state_in = reject ? lbr_pkg::ST_MUL : lbr_pkg::ST_RESULT;
         end
         lbr_pkg::ST_RESULT: begin
            if (out_free) state_in = lbr_pkg::ST_IDLE;
         end
         default: state_in = lbr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      mode_in      = mode_ff;
      lcg_in       = lcg_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      cnt_in       = cnt_ff;
      bits_in      = bits_ff;
      bound_in     = bound_ff;
      dsh_in       = dsh_ff;
      rem_in       = rem_ff;
      pw_in        = pw_ff;
      res_value_in = res_value_ff;
      res_bad_in   = res_bad_ff;
      value_in     = value_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) rsp_valid_in = 1'b0;

      case (state_ff)
         lbr_pkg::ST_IDLE: begin
            if (req_xfer) begin
               mode_in      = lbr_pkg::mode_type'(req_ch.mode);
               bits_in      = req_ch.bits_wanted;
               bound_in     = req_ch.bound;
               acc_in       = lbr_pkg::LCG_ADD;
               mcand_in     = lcg_ff;
               cnt_in       = '0;
               res_value_in = '0;
               res_bad_in   = 1'b1;
               if (lbr_pkg::mode_type'(req_ch.mode) == lbr_pkg::MODE_RESEED) begin
                  lcg_in = req_ch.seed_in[lbr_pkg::STATE_W-1:0] ^ lbr_pkg::LCG_MUL;
               end
            end
         end
         lbr_pkg::ST_MUL: begin
            acc_in   = mul_sum;
            mcand_in = mcand_ff << 1;
            cnt_in   = cnt_ff + 1'b1;
            if (mul_last) lcg_in = mul_sum;
         end
         lbr_pkg::ST_POST: begin
            res_bad_in   = 1'b0;
            res_value_in = raw_value;
            dsh_in       = lcg_ff[lbr_pkg::STATE_W-1 -: lbr_pkg::DRAW_W];
            rem_in       = '0;
            cnt_in       = '0;
            pw_in        = bound_ff;
         end
         lbr_pkg::ST_SHIFT: begin
            if (pw_ff[lbr_pkg::VALUE_W-1]) begin
               res_value_in = {1'b0, dsh_ff};
            end else begin
               dsh_in = dsh_ff >> 1;
               pw_in  = pw_ff << 1;
            end
         end
         lbr_pkg::ST_DIV: begin
            // restoring step; dividend rotates back to the draw after 31 steps
            if (rem_trial >= bound_ff) begin
               rem_in = lbr_pkg::DRAW_W'(rem_trial - bound_ff);
            end else begin
               rem_in = rem_trial[lbr_pkg::DRAW_W-1:0];
            end
            dsh_in = {dsh_ff[lbr_pkg::DRAW_W-2:0], dsh_ff[lbr_pkg::DRAW_W-1]};
            cnt_in = cnt_ff + 1'b1;
         end
         lbr_pkg::ST_CHECK: begin
            if (reject) begin
               acc_in   = lbr_pkg::LCG_ADD;
               mcand_in = lcg_ff;
               cnt_in   = '0;
            end else begin
               res_value_in = {1'b0, rem_ff};
            end
         end
         lbr_pkg::ST_RESULT: begin
            if (out_free) begin
               value_in     = res_value_ff;
               bad_in       = res_bad_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lcg_ff       <= lbr_pkg::LCG_MUL;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lcg_ff       <= lcg_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      cnt_ff       <= cnt_in;
      bits_ff      <= bits_in;
      bound_ff     <= bound_in;
      dsh_ff       <= dsh_in;
      rem_ff       <= rem_in;
      pw_ff        <= pw_in;
      res_value_ff <= res_value_in;
      res_bad_ff   <= res_bad_in;
      value_ff     <= value_in;
      bad_ff       <= bad_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.value     = value_ff;
   assign rsp_ch.bad_bound = bad_ff;

endmodule

[rtl/lbr_checker.sv]
`timescale 1ns / 1ps
// Port-level assertions for the LCG random source, bound to its top level.
module lbr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [lbr_pkg::MODE_W-1:0]      req_mode,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [lbr_pkg::VALUE_W-1:0]     rsp_value,
   input logic                            rsp_bad_bound
);

   logic req_xfer;
   logic draw_xfer;
   logic reseed_xfer;

   assign req_xfer    = req_valid && req_ready;
   assign draw_xfer   = req_xfer && (req_mode == lbr_pkg::MODE_RAW ||
                                     req_mode == lbr_pkg::MODE_BOUNDED);
   assign reseed_xfer = req_xfer && (req_mode == lbr_pkg::MODE_RESEED);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_bound |-> rsp_value == '0)
      else $error("bad bound response with nonzero value");

   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      draw_xfer |=> !req_ready)
      else $error("new request taken while a draw is in progress");

   a_reseed_quiet: assert property (@(posedge clock) disable iff (reset)
      reseed_xfer |=> !$rose(rsp_valid))
      else $error("reseed produced a response");

endmodule

bind lcg48_bounded_random_top lbr_checker u_lbr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_mode      (req_ch.mode),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_value     (rsp_ch.value),
   .rsp_bad_bound (rsp_ch.bad_bound)
);

[verif/lcg48_bounded_random_top_tb.sv]
`timescale 1ns / 1ps
// Testbench for the 48-bit LCG random source: directed, random and backpressure tests.
module lcg48_bounded_random_top_tb;

   localparam logic [lbr_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;
   localparam int HOLD_CYCLES = 400;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic signed [lbr_pkg::VALUE_W-1:0] value;
      logic                               bad_bound;
   } draw_result_type;

   logic clock = 1'b0;
   logic reset;

   lbr_req_if req_ch();
   lbr_rsp_if rsp_ch();

   lcg48_bounded_random_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [lbr_pkg::STATE_W-1:0] gen_state;
   draw_result_type             pending_draws[$];
   int                          mismatches = 0;
   int                          src_idle_pct = 0;
   int                          sink_stall_pct = 0;
   int                          hold_req = 0;
   int                          idle_cycles = 0;

   // advance the generator and take the top nbits
   function automatic logic [31:0] step_gen(input int unsigned nbits);
      gen_state = gen_state * lbr_pkg::LCG_MUL + lbr_pkg::LCG_ADD;
      if (nbits == 0) begin
         return 32'd0;
      end
      if (nbits > 32) begin
         nbits = 32;
      end
      return 32'(gen_state >> (lbr_pkg::STATE_W - nbits));
   endfunction

   task automatic predict_draw(input logic [lbr_pkg::MODE_W-1:0] m,
                               input logic [lbr_pkg::SEED_W-1:0] s,
                               input logic [lbr_pkg::BITS_W-1:0] nb,
                               input logic [lbr_pkg::VALUE_W-1:0] bd);
      draw_result_type res;
      logic [31:0]     d;
      logic [31:0]     r;
      res = '0;
      case (m)
         lbr_pkg::MODE_RESEED: begin
            gen_state = lbr_pkg::STATE_W'(s ^ lbr_pkg::SEED_W'(lbr_pkg::LCG_MUL));
         end
         lbr_pkg::MODE_RAW: begin
            res.value = step_gen(nb);
            pending_draws.push_back(res);
         end
         lbr_pkg::MODE_BOUNDED: begin
            if (bd == 32'd0 || bd[31]) begin
               res.bad_bound = 1'b1;
            end else if ((bd & (bd - 32'd1)) == 32'd0) begin
               d = step_gen(lbr_pkg::DRAW_W);
               res.value = 32'((64'(bd) * 64'(d)) >> lbr_pkg::DRAW_W);
            end else begin
               do begin
                  d = step_gen(lbr_pkg::DRAW_W);
                  r = d % bd;
               end while (((d - r + (bd - 32'd1)) & 32'h8000_0000) != 32'd0);
               res.value = r;
            end
            pending_draws.push_back(res);
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_draw(input logic signed [lbr_pkg::VALUE_W-1:0] v, input logic bb);
      draw_result_type exp_res;
      if (pending_draws.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_MAX) begin
            $display("unexpected result: value %0d bad_bound %0b", v, bb);
         end
      end else begin
         exp_res = pending_draws.pop_front();
         if (exp_res.value !== v || exp_res.bad_bound !== bb) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("mismatch: value exp %0d got %0d, bad_bound exp %0b got %0b",
                        exp_res.value, v, exp_res.bad_bound, bb);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gen_state = lbr_pkg::LCG_MUL;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_draw(req_ch.mode, req_ch.seed_in, req_ch.bits_wanted, req_ch.bound);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_draw(rsp_ch.value, rsp_ch.bad_bound);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("lcg48_bounded_random_top_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random stalls plus an optional long hold-off
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
         end
         if (reset) begin
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   task automatic send_item(input logic [lbr_pkg::MODE_W-1:0] m,
                            input logic [lbr_pkg::SEED_W-1:0] s,
                            input logic [lbr_pkg::BITS_W-1:0] nb,
                            input logic [lbr_pkg::VALUE_W-1:0] bd);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= m;
      req_ch.seed_in     <= s;
      req_ch.bits_wanted <= nb;
      req_ch.bound       <= bd;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   function automatic logic [lbr_pkg::VALUE_W-1:0] rand_bound();
      case ($urandom_range(5))
         0: return 32'd1 << $urandom_range(30);
         1: return 32'($urandom_range(1, 100));
         2: return 32'($urandom_range(1, 32'h7FFF_FFFF));
         3: return 32'h4000_0000 + 32'($urandom_range(1, 32'h3FFF_FFFF));
         4: begin
            if ($urandom_range(1) == 0) begin
               return 32'd0 - 32'($urandom_range(3));
            end
            return {1'b1, 31'($urandom)};
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_item(lbr_pkg::MODE_RAW, '0, 6'd32, '0);
      send_item(lbr_pkg::MODE_RAW, '0, 6'd0, '0);
      send_item(lbr_pkg::MODE_RAW, '0, 6'd1, '0);
      send_item(lbr_pkg::MODE_RAW, '0, 6'd31, '0);
      send_item(lbr_pkg::MODE_RAW, '0, 6'd33, '0);
      send_item(lbr_pkg::MODE_RAW, '0, 6'd63, '0);
      send_item(lbr_pkg::MODE_BOUNDED, '0, '0, 32'd0);
      send_item(lbr_pkg::MODE_BOUNDED, '0, '0, 32'hFFFF_FFFF);
      send_item(lbr_pkg::MODE_BOUNDED, '0, '0, 32'h8000_0000);
      send_item(lbr_pkg::MODE_BOUNDED, '0, '0, 32'd1);
      send_item(lbr_pkg::MODE_BOUNDED, '0, '0, 32'd2);
      send_item(lbr_pkg::MODE_BOUNDED, '0, '0, 32'h4000_0000);
      send_item(lbr_pkg::MODE_BOUNDED, '0, '0, 32'h7FFF_FFFF);
      send_item(lbr_pkg::MODE_BOUNDED, '0, '0, 32'd3);
      send_item(lbr_pkg::MODE_BOUNDED, '0, '0, 32'h4000_0001);
      send_item(lbr_pkg::MODE_RESEED, 64'd0, '0, '0);
      send_item(lbr_pkg::MODE_RAW, '0, 6'd32, '0);
      send_item(lbr_pkg::MODE_RESEED, '1, '0, '0);
      send_item(lbr_pkg::MODE_BOUNDED, '0, '0, 32'd10);
      send_item(lbr_pkg::MODE_RESEED, 64'h8000_0000_0000_0000, '0, '0);
      send_item(MODE_UNUSED, '1, '1, '1);
      send_item(lbr_pkg::MODE_RAW, '0, 6'd16, '0);
      // seed that cancels the scramble: state becomes zero
      send_item(lbr_pkg::MODE_RESEED, 64'(lbr_pkg::LCG_MUL), '0, '0);
      send_item(lbr_pkg::MODE_RAW, '0, 6'd48, '0);
      send_item(lbr_pkg::MODE_BOUNDED, '0, '0, 32'd100);
   endtask

   task automatic test_random(input int n_items, input int src_pct, input int sink_pct);
      int                         sent;
      int                         pick;
      logic [lbr_pkg::MODE_W-1:0] m;
      src_idle_pct   = src_pct;
      sink_stall_pct = sink_pct;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            m = lbr_pkg::MODE_RESEED;
         end else if (pick < 40) begin
            m = lbr_pkg::MODE_RAW;
         end else if (pick < 96) begin
            m = lbr_pkg::MODE_BOUNDED;
         end else begin
            m = MODE_UNUSED;
         end
         send_item(m, {$urandom, $urandom},
                   ($urandom_range(9) == 0) ? lbr_pkg::BITS_W'($urandom_range(63))
                                            : lbr_pkg::BITS_W'($urandom_range(1, 32)),
                   rand_bound());
         sent++;
      end
   endtask

   // receiver holds off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      hold_req = HOLD_CYCLES;
      repeat (12) begin
         send_item(($urandom_range(1) == 0) ? lbr_pkg::MODE_RAW : lbr_pkg::MODE_BOUNDED,
                   {$urandom, $urandom}, lbr_pkg::BITS_W'($urandom_range(1, 32)),
                   rand_bound());
      end
   endtask

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.mode        <= lbr_pkg::MODE_RESEED;
      req_ch.seed_in     <= '0;
      req_ch.bits_wanted <= '0;
      req_ch.bound       <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(360, 0, 0);
      test_random(360, 79, 0);
      test_backpressure();
      test_random(360, 0, 79);
      test_random(360, 7, 7);
      req_ch.valid <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_draws.size() == 0) begin
         $display("lcg48_bounded_random_top_tb OK");
      end else begin
         $display("lcg48_bounded_random_top_tb NOT OK");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/lbr_pkg.sv
rtl/lbr_req_if.sv
rtl/lbr_rsp_if.sv
rtl/lcg48_bounded_random_top.sv
rtl/lbr_checker.sv
verif/lcg48_bounded_random_top_tb.sv
